// ===== hw/rtl/bsf_pkg.sv =====
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants for the byte stuffing framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam logic [7:0]  FLAG_START = 8'h7E;
  localparam logic [7:0]  FLAG_END   = 8'h7F;
  localparam logic [7:0]  ESCAPE     = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  // Kind of the byte being emitted for the held item.
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_ESC   = 2'd1;
  localparam logic [1:0] KIND_DATA  = 2'd2;
  localparam logic [1:0] KIND_END   = 2'd3;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        run_last;
    logic        frame_done;
    logic [15:0] frame_length;
  } bsf_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  kind_next;
    logic        final_slot;
    logic        inside_next;
    logic [15:0] count_next;
  } bsf_ctrl_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ===== hw/rtl/bsf_expand.sv =====
// ----------------------------------------------------------------------------
// bsf_expand
// Picks the framed byte for the current slot of the held payload byte and
// works out the frame state after it.
// ----------------------------------------------------------------------------
module bsf_expand (
  input  logic              fresh,
  input  logic [1:0]        phase,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic              inside_frame,
  input  logic [15:0]       framed_count,
  output bsf_pkg::bsf_result_t result,
  output bsf_pkg::bsf_ctrl_t   ctrl
);
  import bsf_pkg::*;

  logic        esc;
  logic [1:0]  kind;
  logic [15:0] end_length;

  assign esc = (data_byte == ESCAPE) || (data_byte == FLAG_START) ||
               (data_byte == FLAG_END);
  assign end_length = sat_inc(framed_count);

  always_comb begin
    // The first slot of a byte depends on whether a frame is already open.
    if (fresh) begin
      if (!inside_frame) kind = KIND_START;
      else if (esc) kind = KIND_ESC;
      else kind = KIND_DATA;
    end else begin
      kind = phase;
    end
  end

  always_comb begin
    result.out_byte     = data_byte;
    result.frame_done   = 1'b0;
    result.frame_length = 16'd0;
    ctrl.kind           = kind;
    ctrl.kind_next      = KIND_DATA;
    ctrl.final_slot     = 1'b0;
    ctrl.inside_next    = inside_frame;
    ctrl.count_next     = sat_inc(framed_count);
    case (kind)
      KIND_START: begin
        result.out_byte  = FLAG_START;
        ctrl.kind_next   = esc ? KIND_ESC : KIND_DATA;
        ctrl.inside_next = 1'b1;
        ctrl.count_next  = 16'd1;
      end
      KIND_ESC: begin
        result.out_byte = ESCAPE;
        ctrl.kind_next  = KIND_DATA;
      end
      KIND_DATA: begin
        result.out_byte = esc ? (data_byte ^ ESC_XOR) : data_byte;
        ctrl.kind_next  = KIND_END;
        ctrl.final_slot = !last_byte;
      end
      KIND_END: begin
        result.out_byte     = FLAG_END;
        result.frame_done   = 1'b1;
        result.frame_length = end_length;
        ctrl.final_slot     = 1'b1;
        ctrl.inside_next    = 1'b0;
        ctrl.count_next     = 16'd0;
      end
      default: begin
        ctrl.final_slot = 1'b1;
      end
    endcase
    result.run_last = ctrl.final_slot;
  end

endmodule

// ===== hw/rtl/bsf_out_stage.sv =====
// ----------------------------------------------------------------------------
// bsf_out_stage
// Output register that holds one framed byte until the receiver takes it.
// ----------------------------------------------------------------------------
module bsf_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bsf_pkg::bsf_result_t result,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 frame_done,
  output logic [15:0]          frame_length
);
  import bsf_pkg::*;

  bsf_result_t held;

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= result;
    end
  end

  assign out_byte     = held.out_byte;
  assign run_last     = held.run_last;
  assign frame_done   = held.frame_done;
  assign frame_length = held.frame_length;

endmodule

// ===== hw/rtl/byte_stuffing_framer.sv =====
// ----------------------------------------------------------------------------
// byte_stuffing_framer
// HDLC-style byte stuffing framer with start flag, escapes and end flag.
// ----------------------------------------------------------------------------
// Each accepted payload byte yields one to four framed bytes, emitted one per
// cycle while the receiver does not stall, through a single output register:
// a start flag when no frame is open, an escape for 0x7D, 0x7E or 0x7F, the
// data byte, and an end flag carrying the saturating frame length when
// last_byte is set. An input transaction therefore stalls the input until
// its final framed byte is emitted, and the next byte is taken in the same
// cycle the current byte's final framed byte is emitted.
module byte_stuffing_framer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        frame_done,
  output logic [15:0] frame_length
);
  import bsf_pkg::*;

  logic        item_valid;
  logic [7:0]  item_data;
  logic        item_last;
  logic        fresh;
  logic [1:0]  phase;
  logic        inside_frame;
  logic [15:0] framed_count;

  bsf_result_t result;
  bsf_ctrl_t   ctrl;
  logic        out_ready;
  logic        emit;
  logic        accept;

  assign emit     = item_valid && out_ready;
  assign in_stall = item_valid && !(emit && ctrl.final_slot);
  assign accept   = in_valid && !in_stall;

  bsf_expand u_expand (
    .fresh        (fresh),
    .phase        (phase),
    .data_byte    (item_data),
    .last_byte    (item_last),
    .inside_frame (inside_frame),
    .framed_count (framed_count),
    .result       (result),
    .ctrl         (ctrl)
  );

  bsf_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .result       (result),
    .ready        (out_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .frame_length (frame_length)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      fresh      <= 1'b0;
      phase      <= KIND_START;
    end else if (accept) begin
      item_valid <= 1'b1;
      fresh      <= 1'b1;
    end else if (emit && ctrl.final_slot) begin
      item_valid <= 1'b0;
    end else if (emit) begin
      fresh <= 1'b0;
      phase <= ctrl.kind_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_data <= data_byte;
      item_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      framed_count <= 16'd0;
    end else if (emit) begin
      inside_frame <= ctrl.inside_next;
      framed_count <= ctrl.count_next;
    end
  end

  // A closing flag always ends the byte that produced it.
  a_done_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> out_byte == FLAG_END && run_last)
    else $error("frame_done without end flag or run_last");

  // The framer never stalls the input while it holds no byte.
  a_idle_no_stall: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> !in_stall)
    else $error("input stalled while empty");

  // A start flag is only emitted when no frame is open.
  a_start_when_closed: assert property (@(posedge clk) disable iff (rst)
    emit && ctrl.kind == KIND_START |-> !inside_frame)
    else $error("start flag inside an open frame");

  // A closed frame holds no byte count.
  a_closed_count_zero: assert property (@(posedge clk) disable iff (rst)
    !inside_frame |-> framed_count == 16'd0)
    else $error("nonzero count with no frame open");

endmodule

// ===== bench/framer_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framer_scoreboard_pkg
// Scoreboard for the byte stuffing framer. It predicts the framed bytes of
// every accepted payload byte and checks each emitted byte against them.
// ----------------------------------------------------------------------------
package framer_scoreboard_pkg;

  import bsf_pkg::*;

  class framer_scoreboard;

    bsf_result_t framed_bytes_q[$];
    bit          frame_open;
    logic [15:0] frame_bytes;
    int unsigned errors;

    function new();
      frame_open  = 1'b0;
      frame_bytes = 16'd0;
      errors      = 0;
    endfunction

    function bsf_result_t make_byte(logic [7:0] value, logic done, logic [15:0] len);
      bsf_result_t r;
      r.out_byte     = value;
      r.run_last     = 1'b0;
      r.frame_done   = done;
      r.frame_length = len;
      return r;
    endfunction

    // The frame length saturates instead of wrapping.
    function void count_byte();
      if (frame_bytes != COUNT_MAX) frame_bytes = frame_bytes + 16'd1;
    endfunction

    function void note_payload_byte(logic [7:0] data, logic last);
      bsf_result_t run_bytes [4];
      logic [7:0]  value;
      int          n;
      n     = 0;
      value = data;
      if (!frame_open) begin
        frame_open  = 1'b1;
        frame_bytes = 16'd0;
        run_bytes[n] = make_byte(FLAG_START, 1'b0, 16'd0);
        n++;
        count_byte();
      end
      if (value == ESCAPE || value == FLAG_START || value == FLAG_END) begin
        run_bytes[n] = make_byte(ESCAPE, 1'b0, 16'd0);
        n++;
        count_byte();
        value = value ^ ESC_XOR;
      end
      run_bytes[n] = make_byte(value, 1'b0, 16'd0);
      n++;
      count_byte();
      if (last) begin
        count_byte();
        run_bytes[n] = make_byte(FLAG_END, 1'b1, frame_bytes);
        n++;
        frame_open  = 1'b0;
        frame_bytes = 16'd0;
      end
      run_bytes[n-1].run_last = 1'b1;
      for (int i = 0; i < n; i++) framed_bytes_q.push_back(run_bytes[i]);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_framed_byte(bsf_result_t got);
      bsf_result_t want;
      if (framed_bytes_q.size() == 0) begin
        $display("%0t: unexpected output byte, expected none, actual %0h",
                 $time, got.out_byte);
        errors++;
        return;
      end
      want = framed_bytes_q.pop_front();
      check_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
      check_field("run_last", 16'(want.run_last), 16'(got.run_last));
      check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done));
      check_field("frame_length", want.frame_length, got.frame_length);
    endfunction

    function int unsigned pending();
      return framed_bytes_q.size();
    endfunction

  endclass

endpackage

// ===== bench/byte_stuffing_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_stuffing_framer_tb
// Self-checking bench for the byte stuffing framer. Directed packets cover
// flags, escapes and single-byte frames; random packets with bursty input and
// patterned output stalls follow, including one long receiver hold-off.
// Every output byte is checked against a predicted stream.
// ----------------------------------------------------------------------------
module byte_stuffing_framer_tb;

  import bsf_pkg::*;
  import framer_scoreboard_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned TAIL_ITEMS   = 50;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        run_last;
  logic        frame_done;
  logic [15:0] frame_length;

  framer_scoreboard sb;
  bsf_result_t      seen_byte;
  int unsigned      cycle_count;
  bit               gaps_on;
  int unsigned      burst_left;
  bit               hold_req;
  int unsigned      hold_left;
  int unsigned      window_left;
  int unsigned      period_phase;
  stall_mode_t      rx_mode;

  byte_stuffing_framer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .frame_length (frame_length)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Both handshakes are sampled here, before the block updates at this edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_payload_byte(data_byte, last_byte);
      if (out_valid && !out_stall) begin
        seen_byte.out_byte     = out_byte;
        seen_byte.run_last     = run_last;
        seen_byte.frame_done   = frame_done;
        seen_byte.frame_length = frame_length;
        sb.check_framed_byte(seen_byte);
      end
    end
  end

  // Receiver: stall patterns that change every window, plus one long hold-off.
  initial begin
    out_stall    = 1'b0;
    hold_left    = 0;
    window_left  = 0;
    period_phase = 0;
    rx_mode      = STALL_NONE;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (window_left == 0) begin
          rx_mode     = stall_mode_t'($urandom_range(3));
          window_left = $urandom_range(200, 20);
        end else begin
          window_left--;
        end
        case (rx_mode)
          STALL_NONE: out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(4) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(9) < 7);
          default: begin
            out_stall    = (period_phase == 2);
            period_phase = (period_phase == 2) ? 0 : period_phase + 1;
          end
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, or after the idle gap that may follow it.
  task automatic send_item(input logic [7:0] data, input logic last);
    int unsigned gap;
    in_valid  = 1'b1;
    data_byte = data;
    last_byte = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        if (gap != 0) begin
          in_valid  = 1'b0;
          data_byte = 8'($urandom_range(255));
          last_byte = 1'($urandom_range(1));
          repeat (gap) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end
  endtask

  // Biased toward the bytes that need escaping and the extremes.
  function automatic logic [7:0] pick_payload();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return ESCAPE;
    if (r < 20) return FLAG_START;
    if (r < 30) return FLAG_END;
    if (r < 35) return 8'h00;
    if (r < 40) return 8'hFF;
    if (r < 45) return 8'($urandom_range(8'h5F, 8'h5D));
    return 8'($urandom_range(255));
  endfunction

  task automatic send_random_packets(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int unsigned i = 0; i < len; i++) send_item(pick_payload(), i == len - 1);
      sent += len;
    end
  endtask

  initial begin
    sb          = new();
    cycle_count = 0;
    gaps_on     = 1'b1;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    last_byte   = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Single-byte frames, plain and escaped, then mixed multi-byte frames.
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(ESCAPE, 1'b1);
    send_item(FLAG_START, 1'b1);
    send_item(FLAG_END, 1'b1);
    send_item(8'h5D, 1'b1);
    send_item(8'h5E, 1'b1);
    send_item(8'h5F, 1'b1);
    send_item(FLAG_START, 1'b0);
    send_item(ESCAPE, 1'b0);
    send_item(FLAG_END, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7C, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(FLAG_END, 1'b0);
    send_item(FLAG_END, 1'b1);

    // The receiver holds off while the sender keeps offering bytes.
    hold_req = 1'b1;
    send_random_packets(RANDOM_ITEMS);

    send_random_packets(TAIL_ITEMS);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bsf_pkg.sv
hw/rtl/bsf_expand.sv
hw/rtl/bsf_out_stage.sv
hw/rtl/byte_stuffing_framer.sv
bench/framer_scoreboard_pkg.sv
bench/byte_stuffing_framer_tb.sv
